[rtl/core/rsd_pkg.sv]
// shared types and constants for the run-length sprite row decoder
`timescale 1ns / 1ps

package rsd_pkg;

    // operation codes of an input beat
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // fixed blob layout and limits
    localparam int HDR_W_ADDR = 2;
    localparam int HDR_H_ADDR = 3;
    localparam int ROW_TABLE  = 4;
    localparam int DIM_LIMIT  = 1024;
    localparam int REC_LIMIT  = 2048;
    localparam int X_MAX      = 4095;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_ROW,
        PH_RECORD,
        PH_PIXEL
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PIXEL,
        KIND_HDR_OK,
        KIND_BAD_HDR,
        KIND_ROWS_DONE,
        KIND_LONG_REC,
        KIND_OVERRUN,
        KIND_COL_OVF
    } kind_t;

    // sequencer around the blob memory read
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_WAIT_A,
        SQ_WAIT_B
    } seq_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] word;
        logic        first;
        logic        last;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  column;
        logic [9:0]  row;
        logic [15:0] color;
        logic [9:0]  image_width;
        logic [9:0]  image_height;
        logic        final_res;
    } result_t;

    typedef struct packed {
        logic   busy;
        phase_t phase;
    } eng_status_t;

endpackage

[rtl/core/rle_sprite_row_decoder.sv]
// top level of the run-length sprite row decoder
`timescale 1ns / 1ps

// Run-length sprite row decoder. Load beats (operation 0) write blob words into
// an on-chip store of STORE_WORDS 16-bit words; first restarts the store at
// address zero and idles the decoder, last arms it. Each decode beat
// (operation 1) then performs one action: header check, row start, one
// (x offset, run) record or one pixel, giving at most one result beat. A decode
// beat does one registered blob memory read, and a header or record beat two,
// since its two words go one after the other through the single read port. A
// result waiting in the output register holds the decoder only when the next
// action also has a result to give. The store needs no clearing pass after
// reset: reads are bounded by the number of words loaded.
module rle_sprite_row_decoder
    import rsd_pkg::*;
#(
    parameter int STORE_WORDS = 65536
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item_data,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    localparam int AW = $clog2(STORE_WORDS);

    eng_status_t    status;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [15:0]    ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [15:0]    ram_rdata;
    logic           eng_res_valid;
    result_t        eng_res;
    logic           res_room;
    logic           res_valid_reg;
    result_t        res_data_reg;

    // blob store
    rsd_ram #(
        .WIDTH (16),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // decode sequencer and scalar state
    rsd_engine #(
        .STORE_WORDS (STORE_WORDS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_data  (item_data),
        .status     (status),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (eng_res_valid),
        .res_data   (eng_res),
        .res_room   (res_room)
    );

    // input side stalls while a decode beat is in flight
    assign item_stall = status.busy;

    // output register: free when empty or being taken this cycle
    assign res_room = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_room)
        begin
            res_valid_reg <= eng_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_room && eng_res_valid)
        begin
            res_data_reg <= eng_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // a final result always carries an error or end status, never data
    a_final_kind : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.final_res |->
            res_data.kind != KIND_PIXEL && res_data.kind != KIND_HDR_OK)
        else $error("final result with a data kind");

    // the last load beat arms the header check and frees the input at once
    a_last_arms : assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item_data.operation == OP_LOAD &&
            item_data.last |=> status.phase == PH_HEADER && !status.busy)
        else $error("last load beat did not arm the decoder");

    // handing over a final result idles the decoder
    a_final_idles : assert property (@(posedge clk) disable iff (!rst_n)
        eng_res_valid && res_room && eng_res.final_res |=>
            status.phase == PH_IDLE && !status.busy)
        else $error("decoder not idle after a final result");

endmodule

[rtl/core/rsd_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module rsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/rsd_engine.sv]
// decode sequencer: loads the blob, reads words and walks header, rows, records, pixels
`timescale 1ns / 1ps

module rsd_engine
    import rsd_pkg::*;
#(
    parameter int STORE_WORDS = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  item_t                          item_data,
    output eng_status_t                    status,
    output logic                           ram_we,
    output logic [$clog2(STORE_WORDS)-1:0] ram_waddr,
    output logic [15:0]                    ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(STORE_WORDS)-1:0] ram_raddr,
    input  logic [15:0]                    ram_rdata,
    output logic                           res_valid,
    output result_t                        res_data,
    input  logic                           res_room
);

    localparam int AW  = $clog2(STORE_WORDS);
    localparam int WLW = $clog2(STORE_WORDS + 1);
    localparam int PW0 = $clog2(STORE_WORDS + 2);
    localparam int PW  = (PW0 > 17) ? PW0 : 17;

    seq_t            seq_reg, seq_next;
    phase_t          phase_reg, phase_next;
    logic [WLW-1:0]  wl_reg, wl_next;
    logic [PW-1:0]   rp_reg, rp_next;
    logic [11:0]     cx_reg, cx_next;
    logic [9:0]      cy_reg, cy_next;
    logic [9:0]      hw_reg, hw_next;
    logic [9:0]      hh_reg, hh_next;
    logic [10:0]     left_reg, left_next;
    logic [15:0]     a_reg, a_next;

    logic            accept;
    logic            two_word;
    logic [PW-1:0]   addr1, addr2, wl_ext;
    logic            fetch_ok;
    logic [WLW-1:0]  wl_base;
    logic            exec;
    logic [15:0]     op_a, op_b;
    logic            emit;
    result_t         res_c;
    logic [16:0]     rec_sum;
    logic [10:0]     cy_inc;
    logic [12:0]     cx_sum;
    logic [10:0]     left_dec;

    assign accept = item_valid && (seq_reg == SQ_IDLE);
    assign status = '{busy: (seq_reg != SQ_IDLE), phase: phase_reg};
    assign wl_ext = PW'(wl_reg);

    // addresses of the word(s) the current phase needs
    always_comb
    begin
        addr1    = '0;
        addr2    = '0;
        two_word = 1'b0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                addr1    = PW'(HDR_W_ADDR);
                addr2    = PW'(HDR_H_ADDR);
                two_word = 1'b1;
            end
            PH_ROW:
            begin
                addr1 = PW'(ROW_TABLE) + PW'(cy_reg);
            end
            PH_RECORD:
            begin
                addr1    = rp_reg;
                addr2    = rp_reg + PW'(1);
                two_word = 1'b1;
            end
            PH_PIXEL:
            begin
                addr1 = rp_reg;
            end
            default:
            begin
                addr1 = '0;
            end
        endcase
    end

    assign fetch_ok = (addr1 < wl_ext) && (!two_word || (addr2 < wl_ext));

    assign rec_sum  = {1'b0, op_a} + {1'b0, op_b};
    assign cy_inc   = {1'b0, cy_reg} + 11'd1;
    assign cx_sum   = {1'b0, cx_reg} + {2'b00, op_a[10:0]};
    assign left_dec = (left_reg != '0) ? (left_reg - 11'd1) : left_reg;

    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        wl_next    = wl_reg;
        rp_next    = rp_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        hw_next    = hw_reg;
        hh_next    = hh_reg;
        left_next  = left_reg;
        a_next     = a_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = item_data.word;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        exec       = 1'b0;
        op_a       = ram_rdata;
        op_b       = '0;
        emit       = 1'b0;
        res_c      = '0;
        wl_base    = item_data.first ? '0 : wl_reg;

        unique case (seq_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    if (item_data.operation == OP_LOAD)
                    begin
                        if (item_data.first)
                        begin
                            phase_next = PH_IDLE;
                        end
                        wl_next = wl_base;
                        if (wl_base < WLW'(STORE_WORDS))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = wl_base[AW-1:0];
                            wl_next   = wl_base + WLW'(1);
                        end
                        if (item_data.last)
                        begin
                            phase_next = PH_HEADER;
                            rp_next    = '0;
                        end
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = addr1[AW-1:0];
                        seq_next  = SQ_WAIT_A;
                    end
                end
            end
            SQ_WAIT_A:
            begin
                if (two_word)
                begin
                    a_next    = ram_rdata;
                    ram_re    = 1'b1;
                    ram_raddr = addr2[AW-1:0];
                    seq_next  = SQ_WAIT_B;
                end
                else
                begin
                    exec = 1'b1;
                end
            end
            SQ_WAIT_B:
            begin
                exec = 1'b1;
                op_a = a_reg;
                op_b = ram_rdata;
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase

        if (exec)
        begin
            // decide the action and its result from the fetched word(s)
            if (!fetch_ok)
            begin
                emit            = 1'b1;
                res_c.kind      = KIND_OVERRUN;
                res_c.final_res = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        emit = 1'b1;
                        if ((op_a == '0) || (op_a >= 16'(DIM_LIMIT)) ||
                            (op_b == '0) || (op_b >= 16'(DIM_LIMIT)))
                        begin
                            res_c.kind      = KIND_BAD_HDR;
                            res_c.final_res = 1'b1;
                        end
                        else
                        begin
                            hw_next            = op_a[9:0];
                            hh_next            = op_b[9:0];
                            cx_next            = '0;
                            cy_next            = '0;
                            left_next          = '0;
                            phase_next         = PH_ROW;
                            res_c.kind         = KIND_HDR_OK;
                            res_c.image_width  = op_a[9:0];
                            res_c.image_height = op_b[9:0];
                        end
                    end
                    PH_ROW:
                    begin
                        rp_next    = PW'(ROW_TABLE) + PW'(hh_reg) + PW'(op_a);
                        cx_next    = '0;
                        phase_next = PH_RECORD;
                    end
                    PH_RECORD:
                    begin
                        if (rec_sum >= 17'(REC_LIMIT))
                        begin
                            emit            = 1'b1;
                            res_c.kind      = KIND_LONG_REC;
                            res_c.final_res = 1'b1;
                        end
                        else
                        begin
                            rp_next = rp_reg + PW'(2);
                            if (rec_sum == '0)
                            begin
                                // end of row record
                                cy_next = cy_inc[9:0];
                                if (cy_inc >= {1'b0, hh_reg})
                                begin
                                    emit            = 1'b1;
                                    res_c.kind      = KIND_ROWS_DONE;
                                    res_c.final_res = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_ROW;
                                end
                            end
                            else
                            begin
                                cx_next   = (cx_sum > 13'(X_MAX)) ? 12'(X_MAX)
                                                                  : cx_sum[11:0];
                                left_next = op_b[10:0];
                                if (op_b != '0)
                                begin
                                    phase_next = PH_PIXEL;
                                end
                            end
                        end
                    end
                    PH_PIXEL:
                    begin
                        emit = 1'b1;
                        if (cx_reg >= {2'b00, hw_reg})
                        begin
                            res_c.kind      = KIND_COL_OVF;
                            res_c.final_res = 1'b1;
                        end
                        else
                        begin
                            res_c.kind   = KIND_PIXEL;
                            res_c.column = cx_reg[9:0];
                            res_c.row    = cy_reg;
                            res_c.color  = op_a;
                            cx_next      = cx_reg + 12'd1;
                            rp_next      = rp_reg + PW'(1);
                            left_next    = left_dec;
                            if (left_dec == '0)
                            begin
                                phase_next = PH_RECORD;
                            end
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end

            if (res_c.final_res)
            begin
                phase_next = PH_IDLE;
            end

            if (emit && !res_room)
            begin
                // output slot busy: hold everything, read data stays put
                phase_next = phase_reg;
                rp_next    = rp_reg;
                cx_next    = cx_reg;
                cy_next    = cy_reg;
                hw_next    = hw_reg;
                hh_next    = hh_reg;
                left_next  = left_reg;
            end
            else
            begin
                seq_next = SQ_IDLE;
            end
        end
    end

    assign res_valid = exec && emit;
    assign res_data  = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SQ_IDLE;
            phase_reg <= PH_IDLE;
            wl_reg    <= '0;
            rp_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            hw_reg    <= '0;
            hh_reg    <= '0;
            left_reg  <= '0;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            wl_reg    <= wl_next;
            rp_reg    <= rp_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            hw_reg    <= hw_next;
            hh_reg    <= hh_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
    end

endmodule
